// File: sv/lssc_pkg.sv
// ----------------------------------------------------------------------------
// lssc_pkg
// shared constants, codes and types of the light seek scan controller
// ----------------------------------------------------------------------------
package lssc_pkg;

  // scan geometry and sampling
  localparam int ANGLE_STEP          = 5;
  localparam int MAX_ANGLE           = 180;
  localparam int SAMPLES_PER_READING = 5;
  localparam int ADC_BITS            = 10;

  // port widths
  localparam int MODE_W     = 2;
  localparam int SAMPLE_W   = 10;
  localparam int ANGLE_W    = 8;
  localparam int LEVEL_W    = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int QUEUE_DEPTH = 2;

  // sample bits above the converter width are dropped
  localparam logic [SAMPLE_W-1:0] ADC_MASK = SAMPLE_W'((1 << ADC_BITS) - 1);

  // input item kinds as they arrive on the mode field
  typedef logic [MODE_W-1:0] mode_t;
  localparam mode_t MODE_TICK   = 2'd0;
  localparam mode_t MODE_PRESS  = 2'd1;
  localparam mode_t MODE_SAMPLE = 2'd2;
  localparam mode_t MODE_SPARE  = 2'd3;

  // classified beat kinds handed to the back end
  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_PRESS,
    KIND_SAMPLE,
    KIND_NONE
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [SAMPLE_W-1:0] sample;
  } item_t;

  // configuration register indexes
  typedef logic [CFG_IDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_SCAN_INTERVAL    = 3'd0;
  localparam reg_idx_t REG_LIGHT_THRESHOLD  = 3'd1;
  localparam reg_idx_t REG_RECHECK_INTERVAL = 3'd2;
  localparam reg_idx_t REG_DEBOUNCE         = 3'd3;
  localparam reg_idx_t REG_SWEEP_SETTLE     = 3'd4;
  localparam reg_idx_t REG_RECHECK_SETTLE   = 3'd5;
  localparam reg_idx_t REG_RESTART_SETTLE   = 3'd6;

  // one result beat
  typedef struct packed {
    logic [ANGLE_W-1:0] servo_angle;
    logic               sample_request;
    logic               scanning;
    logic               ready_res;
    logic               restart_shown;
    logic               scan_done;
    logic [ANGLE_W-1:0] best_angle;
    logic [LEVEL_W-1:0] best_level;
    logic               rescan_pending;
  } res_t;

endpackage

// File: sv/light_seek_scan_controller_unit.sv
// ----------------------------------------------------------------------------
// light_seek_scan_controller_unit
// servo light seeker: press or timer driven sweeps, averaging, parked rechecks
// ----------------------------------------------------------------------------
// Every accepted beat (1 ms tick, button press or ADC sample) yields exactly
// one result beat. Beats enter a two-entry queue and the back end executes one
// beat per cycle, computing its whole state update combinationally, so the
// block sustains one beat per clock while out_ready does not stall it; a result
// is registered from the queue head into an output register, held there while
// the input side keeps taking beats until the queue is full.
module light_seek_scan_controller_unit #(
  parameter int SAMPLES_PER_READING = lssc_pkg::SAMPLES_PER_READING
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lssc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lssc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lssc_pkg::MODE_W-1:0]     in_mode,
  input  logic [lssc_pkg::SAMPLE_W-1:0]   in_sample_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lssc_pkg::ANGLE_W-1:0]    out_servo_angle,
  output logic                            out_sample_request,
  output logic                            out_scanning,
  output logic                            out_ready_res,
  output logic                            out_restart_shown,
  output logic                            out_scan_done,
  output logic [lssc_pkg::ANGLE_W-1:0]    out_best_angle,
  output logic [lssc_pkg::LEVEL_W-1:0]    out_best_level,
  output logic                            out_rescan_pending
);

  logic            q_full, q_push, q_pop, q_head_valid;
  lssc_pkg::item_t q_item, q_head;
  lssc_pkg::res_t  res;

  lssc_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_sample_value (in_sample_value),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_item          (q_item)
  );

  lssc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_item  (q_head)
  );

  lssc_back #(
    .SAMPLES (SAMPLES_PER_READING)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .head_valid (q_head_valid),
    .head_item  (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (res)
  );

  assign out_servo_angle    = res.servo_angle;
  assign out_sample_request = res.sample_request;
  assign out_scanning       = res.scanning;
  assign out_ready_res      = res.ready_res;
  assign out_restart_shown  = res.restart_shown;
  assign out_scan_done      = res.scan_done;
  assign out_best_angle     = res.best_angle;
  assign out_best_level     = res.best_level;
  assign out_rescan_pending = res.rescan_pending;

endmodule

// File: sv/lssc_front.sv
// ----------------------------------------------------------------------------
// lssc_front
// input side: takes beats, classifies them and pushes them into the queue
// ----------------------------------------------------------------------------
module lssc_front (
  input  logic                         in_valid,
  output logic                         in_ready,
  input  lssc_pkg::mode_t              in_mode,
  input  logic [lssc_pkg::SAMPLE_W-1:0] in_sample_value,
  input  logic                         q_full,
  output logic                         q_push,
  output lssc_pkg::item_t              q_item
);

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.sample = in_sample_value & lssc_pkg::ADC_MASK;
    unique case (in_mode)
      lssc_pkg::MODE_TICK:   q_item.kind = lssc_pkg::KIND_TICK;
      lssc_pkg::MODE_PRESS:  q_item.kind = lssc_pkg::KIND_PRESS;
      lssc_pkg::MODE_SAMPLE: q_item.kind = lssc_pkg::KIND_SAMPLE;
      lssc_pkg::MODE_SPARE:  q_item.kind = lssc_pkg::KIND_NONE;
    endcase
  end

endmodule

// File: sv/lssc_queue.sv
// ----------------------------------------------------------------------------
// lssc_queue
// short fifo between front and back end
// ----------------------------------------------------------------------------
module lssc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lssc_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output lssc_pkg::item_t head_item
);

  localparam int DEPTH = lssc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lssc_pkg::item_t   mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entries start known so the idle head never carries an undefined kind
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_r <= '{default: '0};
    end else if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: sv/lssc_back.sv
// ----------------------------------------------------------------------------
// lssc_back
// back end: timers, sweep sequencer, averaging and result register
// ----------------------------------------------------------------------------
module lssc_back #(
  parameter int SAMPLES = lssc_pkg::SAMPLES_PER_READING
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  lssc_pkg::reg_idx_t              cfg_index,
  input  logic [lssc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            head_valid,
  input  lssc_pkg::item_t                 head_item,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output lssc_pkg::res_t                  out_res
);

  localparam int AW     = lssc_pkg::ANGLE_W;
  localparam int LW     = lssc_pkg::LEVEL_W;
  localparam int CNT_W  = $clog2(SAMPLES + 1);
  localparam int TOT_W  = LW + CNT_W;
  localparam int L_BITS = $clog2(SAMPLES);
  localparam int SHIFT  = TOT_W + L_BITS;
  localparam int RCP_W  = SHIFT + 1;
  localparam int PROD_W = TOT_W + RCP_W;
  // ceil(2^SHIFT / SAMPLES): exact floor division for every total below 2^TOT_W
  localparam logic [RCP_W-1:0] RECIP = RCP_W'(((1 << SHIFT) + SAMPLES - 1) / SAMPLES);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SAMPLES);
  localparam logic [AW:0]      STEP_W  = (AW + 1)'(lssc_pkg::ANGLE_STEP);
  localparam logic [AW:0]      MAX_W   = (AW + 1)'(lssc_pkg::MAX_ANGLE);

  localparam logic [2:0] PH_IDLE           = 3'd0;
  localparam logic [2:0] PH_SWEEP_SETTLE   = 3'd1;
  localparam logic [2:0] PH_SWEEP_SAMPLE   = 3'd2;
  localparam logic [2:0] PH_RECHECK_SETTLE = 3'd3;
  localparam logic [2:0] PH_RECHECK_SAMPLE = 3'd4;
  localparam logic [2:0] PH_RESTART_SETTLE = 3'd5;

  typedef struct packed {
    logic [2:0]       phase;
    logic [15:0]      settle;
    logic [AW-1:0]    pos;
    logic [TOT_W-1:0] tot;
    logic [CNT_W-1:0] cnt;
    logic [AW-1:0]    run_angle;
    logic [LW-1:0]    run_level;
    logic             run_valid;
    logic [AW-1:0]    park_angle;
    logic [LW-1:0]    park_level;
    logic             pending;
    logic             lamp;
  } core_t;

  // configuration
  logic [31:0] scan_int_r, recheck_int_r;
  logic [10:0] thresh_r;
  logic [15:0] debounce_r, sweep_settle_r, recheck_settle_r, restart_settle_r;

  // sequencer state
  core_t       core_r, core_nxt;
  logic [31:0] now_r, now_nxt;
  logic [31:0] press_r, press_nxt;
  logic [31:0] sweep_end_r, sweep_end_nxt;
  logic [31:0] recheck_r, recheck_nxt;

  logic [TOT_W-1:0]  sum;
  logic [CNT_W-1:0]  cnt_inc;
  logic [PROD_W-1:0] prod;
  logic [LW-1:0]     avg;
  logic [LW-1:0]     diff;
  logic              done;
  logic              sweeping;
  lssc_pkg::res_t    res_nxt;
  logic              out_valid_r;
  lssc_pkg::res_t    out_res_r;

  function automatic core_t begin_sampling(core_t s, logic [2:0] ph);
    core_t r;
    r       = s;
    r.phase = ph;
    r.tot   = '0;
    r.cnt   = '0;
    return r;
  endfunction

  function automatic core_t sweep_step(core_t s);
    core_t r;
    r        = s;
    r.lamp   = 1'b0;
    r.phase  = PH_SWEEP_SETTLE;
    r.settle = sweep_settle_r;
    if (sweep_settle_r == '0) begin
      r = begin_sampling(r, PH_SWEEP_SAMPLE);
    end
    return r;
  endfunction

  function automatic core_t clear_run(core_t s);
    core_t r;
    r           = s;
    r.pos       = '0;
    r.run_angle = '0;
    r.run_level = '0;
    r.run_valid = 1'b0;
    return r;
  endfunction

  // a pending press at a step boundary turns into a restart from angle zero
  function automatic core_t step_start(core_t s);
    core_t r;
    r = s;
    if (r.pending) begin
      r         = clear_run(r);
      r.pending = 1'b0;
      r.lamp    = 1'b1;
      r.phase   = PH_RESTART_SETTLE;
      r.settle  = restart_settle_r;
      if (restart_settle_r == '0) begin
        r = sweep_step(r);
      end
    end else begin
      r = sweep_step(r);
    end
    return r;
  endfunction

  assign pop = head_valid && (!out_valid_r || out_ready);

  // averaging datapath, only meaningful on sample beats
  assign sum     = core_r.tot + TOT_W'(head_item.sample);
  assign cnt_inc = core_r.cnt + CNT_W'(1);
  assign prod    = PROD_W'(sum) * PROD_W'(RECIP);
  assign avg     = prod[SHIFT +: LW];
  assign diff    = (avg >= core_r.park_level) ? avg - core_r.park_level
                                              : core_r.park_level - avg;

  always_comb begin
    core_nxt      = core_r;
    now_nxt       = now_r;
    press_nxt     = press_r;
    sweep_end_nxt = sweep_end_r;
    recheck_nxt   = recheck_r;
    done          = 1'b0;
    unique case (head_item.kind)
      lssc_pkg::KIND_TICK: begin
        now_nxt = now_r + 32'd1;
        if (core_r.phase == PH_IDLE) begin
          if (core_r.pending || (now_nxt - sweep_end_r) >= scan_int_r) begin
            core_nxt         = clear_run(core_r);
            core_nxt.pending = 1'b0;
            core_nxt.lamp    = 1'b0;
            core_nxt         = step_start(core_nxt);
          end else if ((now_nxt - recheck_r) >= recheck_int_r) begin
            recheck_nxt     = now_nxt;
            core_nxt.phase  = PH_RECHECK_SETTLE;
            core_nxt.settle = recheck_settle_r;
            if (recheck_settle_r == '0) begin
              core_nxt = begin_sampling(core_nxt, PH_RECHECK_SAMPLE);
            end
          end
        end else if (core_r.phase == PH_SWEEP_SETTLE || core_r.phase == PH_RECHECK_SETTLE ||
                     core_r.phase == PH_RESTART_SETTLE) begin
          if (core_r.settle != '0) begin
            core_nxt.settle = core_r.settle - 16'd1;
          end
          if (core_nxt.settle == '0) begin
            if (core_r.phase == PH_SWEEP_SETTLE) begin
              core_nxt = begin_sampling(core_nxt, PH_SWEEP_SAMPLE);
            end else if (core_r.phase == PH_RECHECK_SETTLE) begin
              core_nxt = begin_sampling(core_nxt, PH_RECHECK_SAMPLE);
            end else begin
              core_nxt = step_start(core_nxt);
            end
          end
        end
      end
      lssc_pkg::KIND_PRESS: begin
        if ((now_r - press_r) > {16'd0, debounce_r}) begin
          core_nxt.pending = 1'b1;
          press_nxt        = now_r;
        end
      end
      lssc_pkg::KIND_SAMPLE: begin
        if (core_r.phase == PH_SWEEP_SAMPLE || core_r.phase == PH_RECHECK_SAMPLE) begin
          core_nxt.tot = sum;
          core_nxt.cnt = cnt_inc;
          if (cnt_inc == CNT_FULL) begin
            if (core_r.phase == PH_SWEEP_SAMPLE) begin
              // first strictly larger reading wins
              if (!core_r.run_valid || avg > core_r.run_level) begin
                core_nxt.run_valid = 1'b1;
                core_nxt.run_level = avg;
                core_nxt.run_angle = core_r.pos;
              end
              if (({1'b0, core_r.pos} + STEP_W) > MAX_W) begin
                core_nxt.park_angle = core_nxt.run_angle;
                core_nxt.park_level = core_nxt.run_level;
                core_nxt.lamp       = 1'b0;
                core_nxt.phase      = PH_IDLE;
                sweep_end_nxt       = now_r;
                done                = 1'b1;
              end else begin
                core_nxt.pos = core_r.pos + STEP_W[AW-1:0];
                core_nxt     = step_start(core_nxt);
              end
            end else begin
              if ({1'b0, diff} >= thresh_r) begin
                core_nxt.pending = 1'b1;
              end
              core_nxt.phase = PH_IDLE;
            end
          end
        end
      end
      lssc_pkg::KIND_NONE: begin
      end
    endcase
  end

  always_comb begin
    sweeping = (core_nxt.phase == PH_SWEEP_SETTLE) || (core_nxt.phase == PH_SWEEP_SAMPLE);
    res_nxt.servo_angle    = (sweeping || core_nxt.phase == PH_RESTART_SETTLE) ?
                             core_nxt.pos : core_nxt.park_angle;
    res_nxt.sample_request = (core_nxt.phase == PH_SWEEP_SAMPLE) ||
                             (core_nxt.phase == PH_RECHECK_SAMPLE);
    res_nxt.scanning       = sweeping;
    res_nxt.ready_res      = (core_nxt.phase == PH_IDLE) ||
                             (core_nxt.phase == PH_RECHECK_SETTLE) ||
                             (core_nxt.phase == PH_RECHECK_SAMPLE);
    res_nxt.restart_shown  = core_nxt.lamp && (core_nxt.phase == PH_RESTART_SETTLE);
    res_nxt.scan_done      = done;
    res_nxt.best_angle     = core_nxt.park_angle;
    res_nxt.best_level     = core_nxt.park_level;
    res_nxt.rescan_pending = core_nxt.pending;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_int_r       <= 32'd5000;
      thresh_r         <= 11'd80;
      recheck_int_r    <= 32'd2000;
      debounce_r       <= 16'd200;
      sweep_settle_r   <= 16'd200;
      recheck_settle_r <= 16'd100;
      restart_settle_r <= 16'd300;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lssc_pkg::REG_SCAN_INTERVAL:    scan_int_r       <= cfg_wdata;
        lssc_pkg::REG_LIGHT_THRESHOLD:  thresh_r         <= cfg_wdata[10:0];
        lssc_pkg::REG_RECHECK_INTERVAL: recheck_int_r    <= cfg_wdata;
        lssc_pkg::REG_DEBOUNCE:         debounce_r       <= cfg_wdata[15:0];
        lssc_pkg::REG_SWEEP_SETTLE:     sweep_settle_r   <= cfg_wdata[15:0];
        lssc_pkg::REG_RECHECK_SETTLE:   recheck_settle_r <= cfg_wdata[15:0];
        lssc_pkg::REG_RESTART_SETTLE:   restart_settle_r <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      core_r      <= '0;
      now_r       <= '0;
      press_r     <= '0;
      sweep_end_r <= '0;
      recheck_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        core_r      <= core_nxt;
        now_r       <= now_nxt;
        press_r     <= press_nxt;
        sweep_end_r <= sweep_end_nxt;
        recheck_r   <= recheck_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register, loaded with every executed beat
  always_ff @(posedge clk) begin
    if (pop) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
